[hdl/hmm_forward_scaled_loglik_unit_defines.svh]
// Assertion macros used by the checker file.
`ifndef HMM_FORWARD_SCALED_LOGLIK_UNIT_DEFINES_SVH
`define HMM_FORWARD_SCALED_LOGLIK_UNIT_DEFINES_SVH

// same-cycle implication
`define HFSL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hfsl check failed");

// next-cycle implication
`define HFSL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hfsl check failed");

`endif

[hdl/hfsl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hfsl_pkg;

  localparam int EMIT_FIELDS = 5;
  localparam int ALPHA_W     = 24;
  localparam int TRANS_W     = 16;
  localparam int EMIT_W      = 32;
  localparam int TSUM_W      = 43;
  localparam int T_W         = 28;
  localparam int A_W         = 37;
  localparam int C_W         = 40;
  localparam int ACC_W       = 40;
  localparam int Q_W         = 24;
  localparam int LN_STEPS    = 20;

  localparam logic [ALPHA_W-1:0] ONE_Q23 = 24'd8388608;
  localparam logic [31:0]        LN2_Q32 = 32'd2977044472;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FRAME = 1'b1;

  localparam logic CFG_STATE_COUNT = 1'b0;
  localparam logic CFG_START_STATE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [2:0]  row_index;
    logic [2:0]  col_index;
    logic [15:0] trans_prob;
    logic [31:0] emit_s0;
    logic [31:0] emit_s1;
    logic [31:0] emit_s2;
    logic [31:0] emit_s3;
    logic [31:0] emit_s4;
    logic        last_frame;
  } in_req_t;

  typedef struct packed {
    logic signed [39:0] ll_sum;
    logic [15:0]        frames_seen;
    logic               zero_stop;
  } out_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEED, ST_SEED_CHK, ST_MAC, ST_DRAIN, ST_EMUL, ST_CHECK,
    ST_DIV_GO, ST_DIV_WAIT, ST_LN_WAIT, ST_ACC, ST_FINISH
  } ctrl_state_t;

  typedef enum logic [2:0] {
    LN_IDLE, LN_NORM, LN_SQ, LN_MUL, LN_RND
  } ln_phase_t;

  typedef struct packed {
    logic [2:0] idx_i;
    logic [2:0] idx_j;
    logic       seq_clr;
    logic       mac_rd;
    logic       emul;
    logic       seed;
    logic       zero_stop;
    logic       alpha_clr;
    logic       ln_go;
    logic       div_go;
    logic       acc_add;
    logic       finish;
  } dp_cmd_t;

  typedef struct packed {
    logic c_zero;
    logic ln_busy;
    logic div_busy;
    logic cnt_zero;
    logic stopped;
    logic out_busy;
    logic last;
  } dp_sts_t;

  // states in use: 0 acts as 1, clipped to the array size and emission fields
  function automatic logic [2:0] states_used(input logic [2:0] sc, input int max_st);
    int lim;
    lim = (max_st < EMIT_FIELDS) ? max_st : EMIT_FIELDS;
    if (sc == 3'd0) return 3'd1;
    if (int'(sc) > lim) return 3'(lim);
    return sc;
  endfunction

endpackage
`default_nettype wire

[hdl/hfsl_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module hfsl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 25
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

[hdl/hfsl_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit a cycle; num <= den assumed
module hfsl_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [hfsl_pkg::A_W-1:0]  num,
  input  wire logic [hfsl_pkg::C_W-1:0]  den,
  output logic                           busy,
  output logic                           done,
  output logic      [hfsl_pkg::Q_W-1:0]  quot
);
  import hfsl_pkg::*;

  logic [C_W-1:0] rem_r, den_r;
  logic [Q_W-1:0] q_r;
  logic [4:0]     k_r;
  logic           busy_r, done_r;
  logic [C_W:0]   rem2;
  logic           ge;
  logic [C_W-1:0] num_x;

  assign num_x = C_W'(num);
  assign rem2  = {rem_r, 1'b0};
  assign ge    = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        den_r  <= den;
        k_r    <= '0;
        if (num_x >= den) begin
          rem_r <= num_x - den;
          q_r   <= Q_W'(1);
        end else begin
          rem_r <= num_x;
          q_r   <= '0;
        end
      end else if (busy_r) begin
        rem_r  <= ge ? C_W'(rem2 - {1'b0, den_r}) : C_W'(rem2);
        q_r    <= {q_r[Q_W-2:0], ge};
        done_r <= (k_r == 5'(Q_W - 2));
        if (k_r == 5'(Q_W - 2)) begin
          busy_r <= 1'b0;
        end else begin
          k_r <= k_r + 5'd1;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

[hdl/hfsl_ln.sv]
`timescale 1ns / 1ps
`default_nettype none
// ln of a UQ.24 value to Q.16: normalise, 20 squarings, scale by ln 2, round
module hfsl_ln (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [hfsl_pkg::C_W-1:0]     c_in,
  output logic                              busy,
  output logic signed [hfsl_pkg::ACC_W-1:0] result
);
  import hfsl_pkg::*;

  ln_phase_t          phase_r;
  logic [C_W-1:0]     x_r;
  logic signed [6:0]  p_r;
  logic [31:0]        m_r;
  logic [19:0]        frac_r;
  logic [4:0]         k_r;
  logic signed [59:0] prod_r;
  logic signed [ACC_W-1:0] res_r;

  logic [63:0]        sq;
  logic [32:0]        s33;
  logic signed [6:0]  pm;
  logic signed [26:0] lval;
  logic signed [32:0] kval;
  logic signed [59:0] prod_c;
  logic [59:0]        mag;
  logic [23:0]        rnd;

  assign sq     = 64'(m_r) * 64'(m_r);
  assign s33    = sq[63:31];
  assign pm     = p_r - 7'sd24;
  assign lval   = $signed({pm, frac_r});
  assign kval   = $signed({1'b0, LN2_Q32});
  assign prod_c = lval * kval;
  assign mag    = prod_r[59] ? 60'(-prod_r) : 60'(prod_r);
  assign rnd    = 24'((mag + 60'h8_0000_0000) >> 36);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= LN_IDLE;
    end else begin
      case (phase_r)
        LN_IDLE: begin
          if (start) begin
            x_r     <= c_in;
            p_r     <= 7'sd39;
            phase_r <= LN_NORM;
          end
        end
        LN_NORM: begin
          if (x_r[C_W-1 -: 8] == 8'd0) begin
            x_r <= x_r << 8;
            p_r <= p_r - 7'sd8;
          end else if (!x_r[C_W-1]) begin
            x_r <= x_r << 1;
            p_r <= p_r - 7'sd1;
          end else begin
            m_r     <= x_r[C_W-1 -: 32];
            frac_r  <= '0;
            k_r     <= '0;
            phase_r <= LN_SQ;
          end
        end
        LN_SQ: begin
          frac_r <= {frac_r[18:0], s33[32]};
          m_r    <= s33[32] ? s33[32:1] : s33[31:0];
          if (k_r == 5'(LN_STEPS - 1)) begin
            phase_r <= LN_MUL;
          end else begin
            k_r <= k_r + 5'd1;
          end
        end
        LN_MUL: begin
          prod_r  <= prod_c;
          phase_r <= LN_RND;
        end
        LN_RND: begin
          res_r   <= prod_r[59] ? -ACC_W'(rnd) : ACC_W'(rnd);
          phase_r <= LN_IDLE;
        end
        default: phase_r <= LN_IDLE;
      endcase
    end
  end

  assign busy   = phase_r != LN_IDLE;
  assign result = res_r;
endmodule
`default_nettype wire

[hdl/hfsl_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module hfsl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_func,
  input  wire logic [2:0]        n_states,
  input  wire hfsl_pkg::dp_sts_t sts,
  output logic                   in_ready,
  output hfsl_pkg::dp_cmd_t      cmd
);
  import hfsl_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic [2:0]  i_r, i_nxt, j_r, j_nxt;
  logic [2:0]  last_idx;
  logic        frame_acc;

  assign last_idx  = n_states - 3'd1;
  assign frame_acc = in_valid && (in_func == FUNC_FRAME);

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    case (state_r)
      ST_IDLE: begin
        i_nxt = '0;
        j_nxt = '0;
        if (frame_acc) begin
          if (sts.cnt_zero)     state_nxt = ST_SEED;
          else if (sts.stopped) state_nxt = ST_FINISH;
          else                  state_nxt = ST_MAC;
        end
      end
      ST_SEED:     state_nxt = ST_SEED_CHK;
      ST_SEED_CHK: state_nxt = sts.c_zero ? ST_FINISH : ST_LN_WAIT;
      ST_MAC: begin
        if (j_r == last_idx) begin
          j_nxt     = '0;
          state_nxt = ST_DRAIN;
        end else begin
          j_nxt = j_r + 3'd1;
        end
      end
      ST_DRAIN: state_nxt = ST_EMUL;
      ST_EMUL: begin
        if (i_r == last_idx) begin
          state_nxt = ST_CHECK;
        end else begin
          i_nxt     = i_r + 3'd1;
          state_nxt = ST_MAC;
        end
      end
      ST_CHECK: begin
        i_nxt     = '0;
        state_nxt = sts.c_zero ? ST_FINISH : ST_DIV_GO;
      end
      ST_DIV_GO: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (!sts.div_busy) begin
          if (i_r == last_idx) begin
            state_nxt = ST_LN_WAIT;
          end else begin
            i_nxt     = i_r + 3'd1;
            state_nxt = ST_DIV_GO;
          end
        end
      end
      ST_LN_WAIT: if (!sts.ln_busy) state_nxt = ST_ACC;
      ST_ACC:     state_nxt = ST_FINISH;
      ST_FINISH:  if (!(sts.last && sts.out_busy)) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.idx_i = i_r;
    cmd.idx_j = j_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.seq_clr = 1'b1;
      end
      ST_SEED: cmd.seed = 1'b1;
      ST_SEED_CHK: begin
        cmd.zero_stop = sts.c_zero;
        cmd.ln_go     = !sts.c_zero;
      end
      ST_MAC:  cmd.mac_rd = 1'b1;
      ST_EMUL: cmd.emul   = 1'b1;
      ST_CHECK: begin
        cmd.alpha_clr = 1'b1;
        cmd.zero_stop = sts.c_zero;
        cmd.ln_go     = !sts.c_zero;
      end
      ST_DIV_GO: cmd.div_go  = 1'b1;
      ST_ACC:    cmd.acc_add = 1'b1;
      ST_FINISH: cmd.finish  = !(sts.last && sts.out_busy);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end
endmodule
`default_nettype wire

[hdl/hfsl_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module hfsl_dp #(
  parameter int MAX_STATES       = 5,
  parameter int FRAME_COUNT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_accept,
  input  wire hfsl_pkg::in_req_t  in_req,
  input  wire logic [2:0]         n_states,
  input  wire logic [2:0]         start_state,
  input  wire hfsl_pkg::dp_cmd_t  cmd,
  output hfsl_pkg::dp_sts_t       sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hfsl_pkg::out_rsp_t      out_rsp
);
  import hfsl_pkg::*;

  localparam int TD  = MAX_STATES * MAX_STATES;
  localparam int TAW = (TD > 1) ? $clog2(TD) : 1;
  localparam int SW  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int CW  = FRAME_COUNT_BITS;

  logic [EMIT_W-1:0]  emit_r [EMIT_FIELDS];
  logic [ALPHA_W-1:0] alpha_r [MAX_STATES];
  logic [A_W-1:0]     a_r [MAX_STATES];
  logic [TSUM_W-1:0]  t_r;
  logic [C_W-1:0]     c_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [CW-1:0]      cnt_r;
  logic               stopped_r, last_r;
  logic               rd_vld_r;
  logic [SW-1:0]      rd_j_r, div_idx_r;
  logic               out_valid_r;
  out_rsp_t           out_rsp_r;

  logic               tw_en;
  logic [TAW-1:0]     tw_addr, tr_addr;
  logic [TRANS_W-1:0] tr_data;
  logic [59:0]        emul_p;
  logic [A_W-1:0]     a_new;
  logic [EMIT_W-1:0]  seed_c;
  logic               ln_busy, div_busy, div_done;
  logic signed [ACC_W-1:0] ln_res;
  logic [Q_W-1:0]     quot;
  logic [ACC_W:0]     acc_sum;
  logic signed [ACC_W-1:0] acc_sat;
  logic [CW-1:0]      cnt_inc;
  logic [31:0]        cnt_ext;
  logic [15:0]        frames;

  assign tw_en   = in_accept && (in_req.func == FUNC_LOAD)
                   && (int'(in_req.row_index) < MAX_STATES)
                   && (int'(in_req.col_index) < MAX_STATES);
  assign tw_addr = TAW'(int'(in_req.row_index) * MAX_STATES + int'(in_req.col_index));
  assign tr_addr = TAW'(int'(cmd.idx_j) * MAX_STATES + int'(cmd.idx_i));

  hfsl_ram #(.WIDTH(TRANS_W), .DEPTH(TD)) u_trans (
    .clk     (clk),
    .wr_en   (tw_en),
    .wr_addr (tw_addr),
    .wr_data (in_req.trans_prob),
    .rd_en   (cmd.mac_rd),
    .rd_addr (tr_addr),
    .rd_data (tr_data)
  );

  hfsl_ln u_ln (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.ln_go),
    .c_in   (c_r),
    .busy   (ln_busy),
    .result (ln_res)
  );

  hfsl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .num   (a_r[SW'(cmd.idx_i)]),
    .den   (c_r),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (quot)
  );

  assign emul_p  = 60'(t_r[TSUM_W-1:15]) * 60'(emit_r[cmd.idx_i]);
  assign a_new   = emul_p[59:23];
  assign seed_c  = (start_state < n_states) ? emit_r[start_state] : '0;
  assign acc_sum = {acc_r[ACC_W-1], acc_r} + {ln_res[ACC_W-1], ln_res};
  assign acc_sat = (acc_sum[ACC_W] != acc_sum[ACC_W-1])
                   ? (acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}})
                   : $signed(acc_sum[ACC_W-1:0]);
  assign cnt_inc = (cnt_r == {CW{1'b1}}) ? cnt_r : cnt_r + CW'(1);
  assign cnt_ext = 32'(cnt_inc);
  assign frames  = (cnt_ext > 32'd65535) ? 16'hFFFF : cnt_ext[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      stopped_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_STATES; k++) alpha_r[k] <= '0;
    end else begin
      rd_vld_r <= cmd.mac_rd;
      rd_j_r   <= SW'(cmd.idx_j);

      if (in_accept && (in_req.func == FUNC_FRAME)) begin
        emit_r[0] <= in_req.emit_s0;
        emit_r[1] <= in_req.emit_s1;
        emit_r[2] <= in_req.emit_s2;
        emit_r[3] <= in_req.emit_s3;
        emit_r[4] <= in_req.emit_s4;
        last_r    <= in_req.last_frame;
      end

      if (cmd.seq_clr) begin
        t_r <= '0;
        c_r <= '0;
      end
      if (rd_vld_r) begin
        t_r <= t_r + TSUM_W'(alpha_r[rd_j_r]) * TSUM_W'(tr_data);
      end
      if (cmd.emul) begin
        a_r[SW'(cmd.idx_i)] <= a_new;
        c_r <= c_r + C_W'(a_new);
        t_r <= '0;
      end

      if (cmd.seed) begin
        c_r <= C_W'(seed_c);
        for (int k = 0; k < MAX_STATES; k++)
          alpha_r[k] <= ((seed_c != '0) && (k == int'(start_state))) ? ONE_Q23 : '0;
      end
      if (cmd.alpha_clr) begin
        for (int k = 0; k < MAX_STATES; k++) alpha_r[k] <= '0;
      end
      if (cmd.zero_stop) stopped_r <= 1'b1;

      if (cmd.div_go) div_idx_r <= SW'(cmd.idx_i);
      if (div_done) alpha_r[div_idx_r] <= quot;

      if (cmd.acc_add) acc_r <= acc_sat;

      if (cmd.finish && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.finish) begin
        if (last_r) begin
          out_rsp_r.ll_sum      <= acc_r;
          out_rsp_r.frames_seen <= frames;
          out_rsp_r.zero_stop   <= stopped_r;
          acc_r       <= '0;
          cnt_r       <= '0;
          stopped_r   <= 1'b0;
          for (int k = 0; k < MAX_STATES; k++) alpha_r[k] <= '0;
        end else begin
          cnt_r <= cnt_inc;
        end
      end
    end
  end

  assign sts.c_zero   = c_r == '0;
  assign sts.ln_busy  = ln_busy;
  assign sts.div_busy = div_busy;
  assign sts.cnt_zero = cnt_r == '0;
  assign sts.stopped  = stopped_r;
  assign sts.out_busy = out_valid_r && !out_ready;
  assign sts.last     = last_r;

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
endmodule
`default_nettype wire

[hdl/hmm_forward_scaled_loglik_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Scaled HMM forward scorer. A request with func = 0 writes one transition
// entry (UQ1.15); a request with func = 1 is a frame of emission
// likelihoods (UQ8.24). The first frame of a sequence seeds alpha from the
// start state; each later frame runs alpha through the transition table,
// weights by the emissions, normalises by the scale c and adds ln(c) in
// Q.16 to a saturating accumulator. A frame with last_frame set returns one
// result (log-likelihood, frame count, zero-stop flag) and clears the
// sequence. A zero scale stops accumulation for the rest of the sequence.
// Timing: a load is taken in the idle state, and a frame after a zero scale
// goes straight to finish. A first frame waits on the ln unit (normalise,
// 20 squarings, multiply, round). In a later frame the matrix-vector product
// does one multiply-accumulate a cycle through the single table read port,
// and the normalisation runs the bit-serial divider once per state; the ln
// of the scale overlaps the divisions, and for a single state may hold the
// frame after the last division. The result sits in an output register, so
// the next request is taken while it waits; only a further last frame waits
// for it to drain. Configuration is via a simple APB port (state_count at
// 0x0, start_state at 0x4); the user must write it only while the block is
// idle, which the block itself does not enforce.
module hmm_forward_scaled_loglik_unit #(
  parameter int MAX_STATES       = 5,
  parameter int FRAME_COUNT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hfsl_pkg::in_req_t  in_req,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hfsl_pkg::out_rsp_t      out_rsp,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);
  import hfsl_pkg::*;

  logic [2:0] state_count_r, start_state_r;
  logic [2:0] n_states;
  logic       cfg_wr;
  logic       in_accept;
  dp_cmd_t    cmd;
  dp_sts_t    sts;

  // registers sit on 4-byte boundaries; bit 2 picks the register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_count_r <= 3'd5;
      start_state_r <= 3'd0;
    end else if (cfg_wr) begin
      case (paddr[2])
        CFG_STATE_COUNT: state_count_r <= pwdata[2:0];
        CFG_START_STATE: start_state_r <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      CFG_STATE_COUNT: prdata = {29'd0, state_count_r};
      CFG_START_STATE: prdata = {29'd0, start_state_r};
      default:         prdata = '0;
    endcase
  end

  // 0 acts as one state; clipped to table size and emission fields
  assign n_states  = states_used(state_count_r, MAX_STATES);
  assign in_accept = in_valid && in_ready;

  hfsl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_req.func),
    .n_states (n_states),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  hfsl_dp #(
    .MAX_STATES       (MAX_STATES),
    .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .in_req      (in_req),
    .n_states    (n_states),
    .start_state (start_state_r),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rsp     (out_rsp)
  );
endmodule
`default_nettype wire

[hdl/hfsl_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "hmm_forward_scaled_loglik_unit_defines.svh"
module hfsl_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire hfsl_pkg::in_req_t in_req,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire hfsl_pkg::out_rsp_t out_rsp,
  input wire logic              pready
);
  import hfsl_pkg::*;

  `HFSL_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `HFSL_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_rsp))
  `HFSL_ASSERT_IMP(a_frames_nonzero, clk, rst_n, out_valid, out_rsp.frames_seen != 16'd0)
  `HFSL_ASSERT_NXT(a_frame_busy, clk, rst_n, in_valid && in_ready && (in_req.func == FUNC_FRAME), !in_ready)
  `HFSL_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready)
endmodule

bind hmm_forward_scaled_loglik_unit hfsl_checker u_hfsl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rsp   (out_rsp),
  .pready    (pready)
);
`default_nettype wire
